// ----- sv/lru_key_value_cache_top_defines.svh -----
// Assertion helpers for the LRU key-value cache checkers.
`ifndef LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH

// Clocked on i_clk, off while i_rst_n is low.
`define LKVC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked on i_clk, also active through reset.
`define LKVC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- sv/lkvc_pkg.sv -----
`timescale 1ns / 1ps

package lkvc_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int CAP_W         = 5;
    localparam int CAP_RESET     = 16;
    localparam int KEY_W         = 32;
    localparam int VAL_W         = 32;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic             opcode;
        logic [KEY_W-1:0] lookup_key;
        logic [VAL_W-1:0] write_value;
    } t_in_item;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
    } t_out_item;

    // Broadcast from the control logic to every entry; the op strobes are already
    // qualified by the item being processed this cycle.
    typedef struct packed {
        logic promote;   // key found: move the matching entry to the front
        logic put_hit;   // key found on a put: overwrite its value
        logic put_miss;  // key absent on a put: evict, age and insert
        logic evict_en;  // store is at capacity
    } t_lane_ctl;

endpackage

// ----- sv/lru_key_value_cache_top.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_ready   i_in_item  (opcode, lookup_key, write_value)
// out       output     o_out_valid / i_out_ready o_out_item (hit, read_value)
// cfg       input      i_cfg_we                  i_cfg_wdata (capacity_in_use)
//
// One item per cycle while the output is not stalled. An item waits in the input
// register, where all entries compare its key in parallel; when it advances, the
// entries update their ranks and its result is registered in the output register.
// Synchronous active-low reset clears all entries; capacity returns to min(16, DEPTH).
// A stalled output holds one result while one more item waits in the input register.

module lru_key_value_cache_top #(
    parameter int DEPTH = lkvc_pkg::DEPTH_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  lkvc_pkg::t_in_item            i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output lkvc_pkg::t_out_item           o_out_item,
    input  logic                          i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]    i_cfg_wdata
);

    localparam int RANK_W = $clog2(DEPTH);
    localparam int OCC_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (OCC_W > lkvc_pkg::CAP_W) ? OCC_W : lkvc_pkg::CAP_W;
    localparam logic [OCC_W-1:0] CAP_RST_EFF =
        OCC_W'((lkvc_pkg::CAP_RESET > DEPTH) ? DEPTH : lkvc_pkg::CAP_RESET);

    logic                r_in_valid;
    lkvc_pkg::t_in_item  r_in;
    logic                r_out_valid;
    lkvc_pkg::t_out_item r_out;
    lkvc_pkg::t_out_item n_out;
    logic [OCC_W-1:0]    r_cap;
    logic [OCC_W-1:0]    n_cap;
    logic [CMP_W-1:0]    cfg_ext;
    logic [OCC_W-1:0]    r_occ;

    logic                adv;
    logic                fire;
    logic                is_put;
    lkvc_pkg::t_lane_ctl ctl;

    logic [DEPTH-1:0]          match;
    logic [DEPTH-1:0]          keep;
    logic [DEPTH-1:0]          free;
    logic [DEPTH-1:0]          ins_sel;
    logic [RANK_W-1:0]         rank  [DEPTH];
    logic [lkvc_pkg::VAL_W-1:0] value [DEPTH];

    logic                       hit_any;
    logic [RANK_W-1:0]          hit_rank;
    logic [lkvc_pkg::VAL_W-1:0] hit_value;
    logic [OCC_W-1:0]           evict_rank;

    assign adv        = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && adv;
    assign o_in_ready = !r_in_valid || adv;
    assign is_put     = (r_in.opcode == lkvc_pkg::OP_PUT);

    // keys are unique among valid entries, so at most one match
    always_comb begin
        hit_rank  = '0;
        hit_value = '0;
        for (int i = 0; i < DEPTH; i++) begin
            hit_rank  = hit_rank  | (rank[i]  & {RANK_W{match[i]}});
            hit_value = hit_value | (value[i] & {lkvc_pkg::VAL_W{match[i]}});
        end
    end
    assign hit_any = |match;

    assign ctl.promote  = fire && hit_any;
    assign ctl.put_hit  = fire && is_put && hit_any;
    assign ctl.put_miss = fire && is_put && !hit_any;
    assign ctl.evict_en = (r_occ >= r_cap);
    assign evict_rank   = r_cap - OCC_W'(1);

    // lowest free slot after eviction
    assign free    = ~keep;
    assign ins_sel = free & (~free + DEPTH'(1));

    for (genvar g = 0; g < DEPTH; g++) begin : g_lane
        lkvc_lane #(
            .RANK_W (RANK_W),
            .OCC_W  (OCC_W)
        ) u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_key        (r_in.lookup_key),
            .i_value      (r_in.write_value),
            .i_hit_rank   (hit_rank),
            .i_evict_rank (evict_rank),
            .i_ins_sel    (ins_sel[g]),
            .o_match      (match[g]),
            .o_keep       (keep[g]),
            .o_rank       (rank[g]),
            .o_value      (value[g])
        );
    end

    always_comb begin
        n_out.hit        = !is_put && hit_any;
        n_out.read_value = n_out.hit ? hit_value : '0;
    end

    // zero acts as one, anything above DEPTH saturates
    assign cfg_ext = CMP_W'(i_cfg_wdata);
    always_comb begin
        if (cfg_ext == '0) begin
            n_cap = OCC_W'(1);
        end else if (cfg_ext > CMP_W'(DEPTH)) begin
            n_cap = OCC_W'(DEPTH);
        end else begin
            n_cap = OCC_W'(cfg_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cap       <= CAP_RST_EFF;
            r_occ       <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg_we) begin
                r_cap <= n_cap;
            end
            if (ctl.put_miss) begin
                // evicting leaves exactly cap-1 entries before the insert
                r_occ <= ctl.evict_en ? r_cap : r_occ + OCC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ----- sv/lkvc_lane.sv -----
`timescale 1ns / 1ps

module lkvc_lane #(
    parameter int RANK_W = 4,
    parameter int OCC_W  = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lkvc_pkg::t_lane_ctl           i_ctl,
    input  logic [lkvc_pkg::KEY_W-1:0]    i_key,
    input  logic [lkvc_pkg::VAL_W-1:0]    i_value,
    input  logic [RANK_W-1:0]             i_hit_rank,
    input  logic [OCC_W-1:0]              i_evict_rank,
    input  logic                          i_ins_sel,
    output logic                          o_match,
    output logic                          o_keep,
    output logic [RANK_W-1:0]             o_rank,
    output logic [lkvc_pkg::VAL_W-1:0]    o_value
);

    logic                       r_valid;
    logic                       n_valid;
    logic [RANK_W-1:0]          r_rank;
    logic [RANK_W-1:0]          n_rank;
    logic [lkvc_pkg::KEY_W-1:0] r_key;
    logic [lkvc_pkg::VAL_W-1:0] r_value;

    assign o_match = r_valid && (r_key == i_key);
    // survives the eviction sweep of a put miss
    assign o_keep  = r_valid && !(i_ctl.evict_en && (OCC_W'(r_rank) >= i_evict_rank));
    assign o_rank  = r_rank;
    assign o_value = r_value;

    always_comb begin
        n_valid = r_valid;
        n_rank  = r_rank;
        if (i_ctl.promote) begin
            if (o_match) begin
                n_rank = '0;
            end else if (r_valid && (r_rank < i_hit_rank)) begin
                n_rank = r_rank + RANK_W'(1);
            end
        end else if (i_ctl.put_miss) begin
            if (i_ins_sel) begin
                n_valid = 1'b1;
                n_rank  = '0;
            end else begin
                n_valid = o_keep;
                if (o_keep) begin
                    n_rank = r_rank + RANK_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else begin
            r_valid <= n_valid;
            r_rank  <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.put_miss && i_ins_sel) begin
            r_key   <= i_key;
            r_value <= i_value;
        end else if (i_ctl.put_hit && o_match) begin
            r_value <= i_value;
        end
    end

endmodule

// ----- sv/lkvc_checker.sv -----
`timescale 1ns / 1ps
`include "lru_key_value_cache_top_defines.svh"

module lkvc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input lkvc_pkg::t_out_item o_out_item
);

    `LKVC_ASSERT_RST(a_rst_empty, !i_rst_n |=> !o_out_valid && o_in_ready, "reset left an item")
    `LKVC_ASSERT(a_miss_zero, o_out_valid && !o_out_item.hit |-> o_out_item.read_value == '0, "miss carries data")
    `LKVC_ASSERT(a_idle_ready, !o_out_valid |-> o_in_ready, "input stalled with empty output")
    `LKVC_ASSERT(a_out_hold, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item), "stalled item changed")

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (.*);
